### rtl/cpt_pkg.sv
package cpt_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int COUNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam int CMP_W = (COUNT_W > 8) ? COUNT_W : 8;

  localparam int IN_BITS = 42;
  localparam int OUT_BITS = 42;
  localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_FIND = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic [7:0] OPAQUE_LIMIT = 8'd128;
  localparam logic [31:0] MAGENTA_OPAQUE = 32'hFF00FFFF;

  typedef struct packed {
    logic [7:0] result_index;
    logic [31:0] colour;
    logic [1:0] status;
  } result_t;

endpackage

### rtl/cpt_ram.sv
module cpt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/colour_palette_table_unit.sv
// Add and find scan the palette one entry per cycle from index 0:
// the scan stops at the first matching entry or after the last used entry.
// Read, transparent, out-of-range and undefined actions do not scan.
// One item at a time; a finished result may wait in the output register while the next is taken.
// Synchronous reset: count 1, entry 0 reads as opaque magenta; no clearing pass.
module colour_palette_table_unit
  import cpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // action, red, green, blue, alpha, entry_index
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // result_index, out_red, out_green, out_blue,
                                     // out_alpha, status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic [COUNT_W-1:0] used, used_next;
  logic [COUNT_W-1:0] scan_addr, scan_addr_next;
  logic [IDX_W-1:0] cmp_addr, cmp_addr_next;
  logic cmp_pend, cmp_pend_next;
  logic [1:0] action, action_next;
  logic [31:0] key, key_next;
  result_t res, res_next;
  result_t out_res;

  logic we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [31:0] ram_q, rd_word;
  logic zero_q;

  logic [1:0] in_action;
  logic [7:0] in_red, in_green, in_blue, in_alpha, in_index;
  logic [CMP_W-1:0] index_ext, used_ext;
  logic take;

  assign in_action = s_tdata[1:0];
  assign in_red    = s_tdata[9:2];
  assign in_green  = s_tdata[17:10];
  assign in_blue   = s_tdata[25:18];
  assign in_alpha  = s_tdata[33:26];
  assign in_index  = s_tdata[41:34];
  assign index_ext = CMP_W'(in_index);
  assign used_ext  = CMP_W'(used);

  assign s_tready = (state == S_IDLE);
  assign take = s_tvalid && s_tready;

  assign rd_word = zero_q ? MAGENTA_OPAQUE : ram_q;

  cpt_ram #(.DEPTH(PALETTE_DEPTH), .WIDTH(32)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (key),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_comb begin
    state_next = state;
    used_next = used;
    scan_addr_next = scan_addr;
    cmp_addr_next = cmp_addr;
    cmp_pend_next = cmp_pend;
    action_next = action;
    key_next = key;
    res_next = res;
    we = 1'b0;
    re = 1'b0;
    waddr = used[IDX_W-1:0];
    raddr = scan_addr[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (take) begin
          action_next = in_action;
          key_next = {in_red, in_green, in_blue, in_alpha};
          res_next = '0;
          scan_addr_next = '0;
          cmp_pend_next = 1'b0;
          if (in_action inside {ACT_ADD, ACT_FIND}) begin
            state_next = (in_alpha >= OPAQUE_LIMIT) ? S_SCAN : S_DONE;
          end else if (in_action == ACT_READ) begin
            if (index_ext < used_ext) begin
              re = 1'b1;
              raddr = IDX_W'(in_index);
              state_next = S_READ;
            end else begin
              res_next.status = ST_RANGE;
              state_next = S_DONE;
            end
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (cmp_pend && rd_word == key) begin
          res_next.result_index = 8'(cmp_addr);
          state_next = S_DONE;
        end else if (scan_addr == used) begin
          if (action == ACT_FIND) begin
            res_next.status = ST_NOT_FOUND;
          end else if (used == COUNT_W'(PALETTE_DEPTH)) begin
            res_next.status = ST_FULL;
          end else begin
            we = 1'b1;
            res_next.result_index = 8'(used);
            used_next = used + 1'b1;
          end
          state_next = S_DONE;
        end else begin
          re = 1'b1;
          cmp_addr_next = scan_addr[IDX_W-1:0];
          scan_addr_next = scan_addr + 1'b1;
          cmp_pend_next = 1'b1;
        end
      end
      S_READ: begin
        res_next.colour = rd_word;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= COUNT_W'(1);
      cmp_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      cmp_pend <= cmp_pend_next;
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_addr <= scan_addr_next;
    cmp_addr <= cmp_addr_next;
    action <= action_next;
    key <= key_next;
    res <= res_next;
    if (re) begin
      zero_q <= (raddr == '0);
    end
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(OUT_W - OUT_BITS){1'b0}}, out_res.status, out_res.colour[7:0],
                    out_res.colour[15:8], out_res.colour[23:16], out_res.colour[31:24],
                    out_res.result_index};

endmodule
